@@ hw/rtl/usmp_pkg.sv @@
// Shared types and constants of the USB-MIDI sysex group packetizer.
package usmp_pkg;

  localparam int GROUP_MAX    = 7;
  localparam int FILL_W       = 3;
  localparam int STREAM_DEPTH = 16;
  localparam int POS_W        = 4;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_END   = 8'hF7;

  typedef enum logic [2:0] {
    CIN_CONT = 3'd4,
    CIN_END1 = 3'd5,
    CIN_END2 = 3'd6,
    CIN_END3 = 3'd7
  } cin_t;

  typedef struct packed {
    logic                         start;
    logic                         flush;
    logic                         end_msg;
    logic [FILL_W-1:0]            count;
    logic [6:0]                   top;
    logic [GROUP_MAX-1:0][6:0]    data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic head_valid;
  } queue_status_t;

endpackage

@@ hw/rtl/usmp_if.sv @@
// Valid/ready channel interfaces for input bytes and output packets.
interface usmp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;
  logic       empty_message;

  modport source (output valid, data_byte, is_last, empty_message, input ready);
  modport sink   (input valid, data_byte, is_last, empty_message, output ready);
endinterface

interface usmp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] code_index;
  logic [7:0] first_byte;
  logic [7:0] second_byte;
  logic [7:0] third_byte;
  logic       last_packet;

  modport source (output valid, code_index, first_byte, second_byte, third_byte,
                  last_packet, input ready);
  modport sink   (input valid, code_index, first_byte, second_byte, third_byte,
                  last_packet, output ready);
endinterface

@@ hw/rtl/usmp_front.sv @@
// Front end: gathers data bytes into groups and issues flush/end commands.
module usmp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  usmp_in_if.sink              in_ch,
  input  usmp_pkg::queue_status_t q_status,
  output usmp_pkg::cmd_t       cmd,
  output logic                 cmd_push
);
  import usmp_pkg::*;

  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [6:0]        top_r, top_nxt;
  logic              f0_sent_r, f0_sent_nxt;
  logic [6:0]        gdata_r [GROUP_MAX];

  logic              accept;
  logic [FILL_W-1:0] fill_inc;
  logic [6:0]        top_add;
  logic              group_done;

  assign in_ch.ready = !q_status.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign fill_inc    = fill_r + FILL_W'(1);
  assign top_add     = in_ch.data_byte[7] ? (7'h40 >> fill_r) : 7'd0;
  assign group_done  = !in_ch.empty_message &&
                       (fill_inc == FILL_W'(GROUP_MAX) || in_ch.is_last);
  assign cmd_push    = accept && (in_ch.empty_message || group_done);

  always_comb begin
    cmd.start = !f0_sent_r;
    if (in_ch.empty_message) begin
      cmd.flush   = (fill_r != '0);
      cmd.end_msg = 1'b1;
      cmd.count   = fill_r;
      cmd.top     = top_r;
      for (int i = 0; i < GROUP_MAX; i++) begin
        cmd.data[i] = gdata_r[i];
      end
    end else begin
      cmd.flush   = 1'b1;
      cmd.end_msg = in_ch.is_last;
      cmd.count   = fill_inc;
      cmd.top     = top_r | top_add;
      for (int i = 0; i < GROUP_MAX; i++) begin
        cmd.data[i] = (FILL_W'(i) == fill_r) ? in_ch.data_byte[6:0] : gdata_r[i];
      end
    end
  end

  always_comb begin
    fill_nxt    = fill_r;
    top_nxt     = top_r;
    f0_sent_nxt = f0_sent_r;
    if (accept) begin
      if (cmd_push) begin
        fill_nxt    = '0;
        top_nxt     = '0;
        f0_sent_nxt = !cmd.end_msg;
      end else begin
        fill_nxt = fill_inc;
        top_nxt  = top_r | top_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r    <= '0;
      top_r     <= '0;
      f0_sent_r <= 1'b0;
    end else begin
      fill_r    <= fill_nxt;
      top_r     <= top_nxt;
      f0_sent_r <= f0_sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !in_ch.empty_message) begin
      gdata_r[fill_r] <= in_ch.data_byte[6:0];
    end
  end

endmodule

@@ hw/rtl/usmp_cmd_queue.sv @@
// Two-entry command queue between the front end and the packet builder.
module usmp_cmd_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  usmp_pkg::cmd_t          push_cmd,
  input  logic                    pop,
  output usmp_pkg::cmd_t          head,
  output usmp_pkg::queue_status_t status
);
  import usmp_pkg::*;

  cmd_t       mem_r [QUEUE_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign status.full       = (count_r == 2'(QUEUE_DEPTH));
  assign status.head_valid = (count_r != 2'd0);
  assign head              = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ hw/rtl/usmp_back.sv @@
// Back end: turns commands into the byte stream and packs it into packets.
module usmp_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  usmp_pkg::queue_status_t q_status,
  input  usmp_pkg::cmd_t          head,
  output logic                    pop,
  usmp_out_if.source              out_ch
);
  import usmp_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [1:0]       cc_r, cc_nxt;
  logic [7:0]       carry_r [2];
  logic [7:0]       carry_nxt [2];
  logic             out_valid_r, out_valid_nxt;
  logic [2:0]       code_r, code_nxt;
  logic [7:0]       b0_r, b0_nxt, b1_r, b1_nxt, b2_r, b2_nxt;
  logic             last_r, last_nxt;

  logic [7:0]       strm [STREAM_DEPTH];
  logic [7:0]       cand [3];
  logic [POS_W-1:0] len, avail, pos_adv;
  logic [1:0]       need, k;
  logic [2:0]       tot;
  logic             fill3, can_emit, emit;

  always_comb begin
    for (int i = 0; i < STREAM_DEPTH; i++) begin
      int j;
      j = i - int'(head.start);
      if (head.start && i == 0) begin
        strm[i] = SYSEX_START;
      end else if (head.flush && j == 0) begin
        strm[i] = {1'b0, head.top};
      end else if (head.flush && j >= 1 && j <= GROUP_MAX && j <= int'(head.count)) begin
        strm[i] = {1'b0, head.data[FILL_W'(j - 1)]};
      end else begin
        strm[i] = 8'd0;
      end
    end
  end

  assign len      = POS_W'(head.start) +
                    (head.flush ? (POS_W'(head.count) + POS_W'(1)) : POS_W'(0));
  assign avail    = len - pos_r;
  assign need     = 2'd3 - cc_r;
  assign k        = (avail < POS_W'(need)) ? avail[1:0] : need;
  assign tot      = 3'(cc_r) + 3'(k);
  assign fill3    = (tot == 3'd3);
  assign pos_adv  = pos_r + POS_W'(k);
  assign can_emit = !out_valid_r || out_ch.ready;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      if (2'(j) < cc_r) begin
        cand[j] = carry_r[j[0]];
      end else begin
        cand[j] = strm[pos_r + POS_W'(j) - POS_W'(cc_r)];
      end
    end
  end

  always_comb begin
    pos_nxt      = pos_r;
    cc_nxt       = cc_r;
    carry_nxt[0] = carry_r[0];
    carry_nxt[1] = carry_r[1];
    pop          = 1'b0;
    emit         = 1'b0;
    code_nxt     = code_r;
    b0_nxt       = b0_r;
    b1_nxt       = b1_r;
    b2_nxt       = b2_r;
    last_nxt     = last_r;
    if (q_status.head_valid) begin
      if (fill3) begin
        if (can_emit) begin
          emit     = 1'b1;
          code_nxt = CIN_CONT;
          b0_nxt   = cand[0];
          b1_nxt   = cand[1];
          b2_nxt   = cand[2];
          last_nxt = 1'b0;
          cc_nxt   = '0;
          pos_nxt  = pos_adv;
          if (pos_adv == len && !head.end_msg) begin
            pop     = 1'b1;
            pos_nxt = '0;
          end
        end
      end else if (head.end_msg) begin
        if (can_emit) begin
          emit     = 1'b1;
          last_nxt = 1'b1;
          case (tot)
            3'd0: begin
              code_nxt = CIN_END1;
              b0_nxt   = SYSEX_END;
              b1_nxt   = 8'd0;
              b2_nxt   = 8'd0;
            end
            3'd1: begin
              code_nxt = CIN_END2;
              b0_nxt   = cand[0];
              b1_nxt   = SYSEX_END;
              b2_nxt   = 8'd0;
            end
            default: begin
              code_nxt = CIN_END3;
              b0_nxt   = cand[0];
              b1_nxt   = cand[1];
              b2_nxt   = SYSEX_END;
            end
          endcase
          cc_nxt  = '0;
          pos_nxt = '0;
          pop     = 1'b1;
        end
      end else begin
        carry_nxt[0] = cand[0];
        carry_nxt[1] = cand[1];
        cc_nxt       = tot[1:0];
        pos_nxt      = '0;
        pop          = 1'b1;
      end
    end
    out_valid_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      cc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      cc_r        <= cc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    carry_r[0] <= carry_nxt[0];
    carry_r[1] <= carry_nxt[1];
    code_r     <= code_nxt;
    b0_r       <= b0_nxt;
    b1_r       <= b1_nxt;
    b2_r       <= b2_nxt;
    last_r     <= last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.code_index  = code_r;
  assign out_ch.first_byte  = b0_r;
  assign out_ch.second_byte = b1_r;
  assign out_ch.third_byte  = b2_r;
  assign out_ch.last_packet = last_r;

endmodule

@@ hw/rtl/usb_midi_sysex_group_packetizer_top.sv @@
// Top level of the USB-MIDI sysex packetizer with 7-bit group packing.
//
//   channel   direction  handshake      payload
//   in_ch     sink       valid/ready    data_byte, is_last, empty_message
//   out_ch    source     valid/ready    code_index, first_byte..third_byte, last_packet
//
// One input item is taken per cycle while the two-entry command queue has room.
// A full or final group, or an empty_message item, becomes one command; the
// packet builder emits at most one packet per cycle.
// Reset is synchronous and clears all control state.
// The output register holds a packet until taken; a stalled output or a run of
// short messages backs up through the queue to in_ch.ready.
module usb_midi_sysex_group_packetizer_top (
  input logic        clk,
  input logic        rst_n,
  usmp_in_if.sink    in_ch,
  usmp_out_if.source out_ch
);
  import usmp_pkg::*;

  cmd_t          push_cmd;
  cmd_t          head;
  logic          push;
  logic          pop;
  queue_status_t q_status;

  usmp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_status (q_status),
    .cmd      (push_cmd),
    .cmd_push (push)
  );

  usmp_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  usmp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_status (q_status),
    .head     (head),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

@@ verif/usb_midi_sysex_group_packetizer_top_test.sv @@
// Self-checking testbench of the USB-MIDI sysex group packetizer: predicts packets per input item.
module usb_midi_sysex_group_packetizer_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import usmp_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    cin_t       code_index;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic       last_packet;
  } sysex_packet_t;

  class sysex_scoreboard;
    logic [6:0]    group_bytes[GROUP_MAX];
    logic [6:0]    top_bits;
    int unsigned   group_count;
    logic [7:0]    held_bytes[2];
    int unsigned   held_count;
    bit            message_open;
    sysex_packet_t expected_packets[$];
    int unsigned   errors;

    function new();
      top_bits = '0;
      group_count = 0;
      held_count = 0;
      message_open = 0;
      errors = 0;
    endfunction

    function void emit(cin_t code, logic [7:0] a, logic [7:0] b, logic [7:0] c,
                       logic last);
      sysex_packet_t p;
      p.code_index = code;
      p.first_byte = a;
      p.second_byte = b;
      p.third_byte = c;
      p.last_packet = last;
      expected_packets.push_back(p);
    endfunction

    function void stream_byte(logic [7:0] v);
      if (held_count == 2) begin
        emit(CIN_CONT, held_bytes[0], held_bytes[1], v, 1'b0);
        held_count = 0;
      end else begin
        held_bytes[held_count] = v;
        held_count++;
      end
    endfunction

    function void flush_group();
      if (group_count == 0) return;
      stream_byte({1'b0, top_bits});
      for (int i = 0; i < group_count; i++) stream_byte({1'b0, group_bytes[i]});
      group_count = 0;
      top_bits = '0;
    endfunction

    function void close_message();
      case (held_count)
        0: emit(CIN_END1, SYSEX_END, 8'h00, 8'h00, 1'b1);
        1: emit(CIN_END2, held_bytes[0], SYSEX_END, 8'h00, 1'b1);
        default: emit(CIN_END3, held_bytes[0], held_bytes[1], SYSEX_END, 1'b1);
      endcase
      held_count = 0;
      message_open = 0;
    endfunction

    function void note_byte(logic [7:0] data, logic last, logic empty);
      if (!message_open) begin
        group_count = 0;
        top_bits = '0;
        held_count = 0;
        stream_byte(SYSEX_START);
        message_open = 1;
      end
      if (empty) begin
        flush_group();
        close_message();
        return;
      end
      group_bytes[group_count] = data[6:0];
      if (data[7]) top_bits |= 7'h40 >> group_count;
      group_count++;
      if (group_count == GROUP_MAX || last) flush_group();
      if (last) close_message();
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_packet(sysex_packet_t got);
      sysex_packet_t want;
      if (expected_packets.size() == 0) begin
        errors++;
        $display("%0t: unexpected packet, expected none actual %0h %0h %0h %0h %0b",
                 $time, got.code_index, got.first_byte, got.second_byte,
                 got.third_byte, got.last_packet);
        return;
      end
      want = expected_packets.pop_front();
      compare_field("code_index", want.code_index, got.code_index);
      compare_field("first_byte", want.first_byte, got.first_byte);
      compare_field("second_byte", want.second_byte, got.second_byte);
      compare_field("third_byte", want.third_byte, got.third_byte);
      compare_field("last_packet", want.last_packet, got.last_packet);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  usmp_in_if  in_ch();
  usmp_out_if out_ch();

  usb_midi_sysex_group_packetizer_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sysex_scoreboard packets_sb;
  int unsigned     send_idle_pct = 0;
  int unsigned     stall_pct = 0;
  int unsigned     bytes_sent = 0;
  int unsigned     quiet_cycles = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    sysex_packet_t got;
    bit moved;
    moved = 0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) moved = 1;
      if (out_ch.valid && out_ch.ready) begin
        moved = 1;
        got.code_index = cin_t'(out_ch.code_index);
        got.first_byte = out_ch.first_byte;
        got.second_byte = out_ch.second_byte;
        got.third_byte = out_ch.third_byte;
        got.last_packet = out_ch.last_packet;
        packets_sb.check_packet(got);
      end
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // call at a falling edge; returns at the falling edge after the item is taken
  task automatic send_byte(logic [7:0] data, logic last, logic empty);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= data;
    in_ch.is_last <= last;
    in_ch.empty_message <= empty;
    do @(posedge clk); while (!in_ch.ready);
    packets_sb.note_byte(data, last, empty);
    bytes_sent++;
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] edges[4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};
    if ($urandom_range(3) == 0) return edges[$urandom_range(3)];
    return 8'($urandom_range(255));
  endfunction

  task automatic send_message(int unsigned len, bit close_by_empty);
    for (int unsigned i = 0; i < len; i++)
      send_byte(pick_byte(), (i == len - 1) && !close_by_empty, 1'b0);
    if (close_by_empty) send_byte(pick_byte(), 1'($urandom_range(1)), 1'b1);
  endtask

  task automatic random_phase(int unsigned idle, int unsigned stall, int unsigned items);
    int unsigned target;
    int unsigned len;
    target = bytes_sent + items;
    send_idle_pct = idle;
    stall_pct = stall;
    while (bytes_sent < target) begin
      len = ($urandom_range(4) == 0) ? $urandom_range(22) : $urandom_range(1, 9);
      if (len == 0) send_message(0, 1'b1);
      else send_message(len, $urandom_range(4) == 0);
    end
  endtask

  initial begin
    logic [7:0] full_group[7] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'hAA};
    packets_sb = new();
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.is_last = 1'b0;
    in_ch.empty_message = 1'b0;
    out_ch.ready = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_byte(8'h5A, 1'b0, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b0);
    for (int i = 0; i < 7; i++) send_byte(full_group[i], i == 6, 1'b0);
    send_byte(8'h80, 1'b0, 1'b0);
    send_byte(8'h7F, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b1, 1'b1);
    for (int i = 0; i < 7; i++) send_byte(~full_group[i], 1'b0, 1'b0);
    send_byte(8'h33, 1'b0, 1'b1);

    random_phase(0, 0, 20);
    random_phase(69, 0, 20);
    random_phase(0, 69, 20);
    random_phase(36, 36, 20);
    in_ch.valid <= 1'b0;

    while (packets_sb.expected_packets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (packets_sb.errors == 0 && packets_sb.expected_packets.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/usmp_pkg.sv
hw/rtl/usmp_if.sv
hw/rtl/usmp_front.sv
hw/rtl/usmp_cmd_queue.sv
hw/rtl/usmp_back.sv
hw/rtl/usb_midi_sysex_group_packetizer_top.sv
verif/usb_midi_sysex_group_packetizer_top_test.sv
